// ----- rtl/llh_pkg.sv -----
`timescale 1ns / 1ps

package llh_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int LINEAR_BITS  = 10;
    localparam int SUB_BITS     = 6;
    localparam int COUNT_BITS   = 32;

    localparam int LINEAR_COUNT = 1 << LINEAR_BITS;
    localparam int NBUCKETS     = LINEAR_COUNT + ((VALUE_BITS - LINEAR_BITS) << SUB_BITS);
    localparam int IDX_W        = $clog2(NBUCKETS);
    localparam int EXP_W        = $clog2(VALUE_BITS);

    localparam int ACTION_W     = 2;
    localparam int LAT_W        = 32;
    localparam int Q_W          = 17;
    localparam int ANSWER_W     = 32;
    localparam int SCOUNT_W     = 32;

    localparam int STAT_W       = 64;
    localparam int Q_FRAC_BITS  = 16;
    localparam int Q_ONE        = 1 << Q_FRAC_BITS;
    localparam int ADD_W        = STAT_W + Q_W;
    localparam int STEP_W       = $clog2(STAT_W);

    localparam logic [ACTION_W-1:0] ACT_RECORD     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PERCENTILE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MEAN       = 2'd2;

    typedef enum logic [1:0] {
        OP_NORM,
        OP_MUL,
        OP_DIV
    } arith_op_t;

    typedef enum logic [1:0] {
        AR_IDLE,
        AR_RUN,
        AR_ROUND,
        AR_DONE
    } arith_state_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REC_NORM,
        ST_REC_READ,
        ST_REC_WRITE,
        ST_TARGET,
        ST_WALK_FIRST,
        ST_WALK,
        ST_MEAN,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic              start;
        arith_op_t         op;
        logic [STAT_W-1:0] a;
        logic [STAT_W-1:0] b;
    } arith_cmd_t;

    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] value;
        logic [EXP_W-1:0]  expo;
    } arith_rsp_t;

    // Upper bound of a bucket: the index itself in the linear range, otherwise
    // ((2^SUB_BITS + sub + 1) << (e - SUB_BITS)) - 1.
    function automatic logic [VALUE_BITS-1:0] bucket_upper(input logic [IDX_W-1:0] b);
        logic [IDX_W-1:0]      rel;
        logic [EXP_W-1:0]      shamt;
        logic [SUB_BITS+1:0]   mant;
        logic [VALUE_BITS:0]   top;
        logic [VALUE_BITS-1:0] res;
        rel   = b - IDX_W'(LINEAR_COUNT);
        shamt = EXP_W'(rel >> SUB_BITS) + EXP_W'(LINEAR_BITS - SUB_BITS);
        mant  = (SUB_BITS+2)'(rel[SUB_BITS-1:0]) + (SUB_BITS+2)'((1 << SUB_BITS) + 1);
        top   = (VALUE_BITS+1)'(mant) << shamt;
        if (b < IDX_W'(LINEAR_COUNT))
        begin
            res = VALUE_BITS'(b);
        end
        else
        begin
            res = VALUE_BITS'(top - (VALUE_BITS+1)'(1));
        end
        return res;
    endfunction

endpackage

// ----- rtl/llh_req_if.sv -----
`timescale 1ns / 1ps

interface llh_req_if;
    logic                          valid;
    logic                          ready;
    logic [llh_pkg::ACTION_W-1:0]  action;
    logic [llh_pkg::LAT_W-1:0]     latency;
    logic [llh_pkg::Q_W-1:0]       quantile_frac;

    modport source (output valid, action, latency, quantile_frac, input ready);
    modport sink   (input valid, action, latency, quantile_frac, output ready);
endinterface

// ----- rtl/llh_rsp_if.sv -----
`timescale 1ns / 1ps

interface llh_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [llh_pkg::ANSWER_W-1:0]  answer;
    logic [llh_pkg::SCOUNT_W-1:0]  sample_count;
    logic                          bad_quantile;

    modport source (output valid, answer, sample_count, bad_quantile, input ready);
    modport sink   (input valid, answer, sample_count, bad_quantile, output ready);
endinterface

// ----- rtl/log_linear_latency_histogram.sv -----
// Record beat: bucket read and write-back, after a leading-one shift loop from 1024 up.
// Percentile beat: a 17-step multiply, rounding, walk setup and result, plus a walk of one
// bucket per cycle through the bucket memory read port (up to 2432 buckets).
// Mean beat: 64-step shared divider. Empty or invalid queries go straight to the result.
// A new beat is accepted while a result waits in the output register.
// Reset: counters clear at once; a sweep of all 2432 buckets zeroes the memory, ready low.
`timescale 1ns / 1ps

module log_linear_latency_histogram (
    input  logic      clk,
    input  logic      rst_n,
    llh_req_if.sink   req,
    llh_rsp_if.source rsp
);

    llh_pkg::seq_state_t               state_reg, state_next;
    logic [llh_pkg::IDX_W-1:0]         clr_idx_reg, clr_idx_next;
    logic [llh_pkg::STAT_W-1:0]        total_reg, total_next;
    logic [llh_pkg::STAT_W-1:0]        sum_reg, sum_next;
    logic                              out_valid_reg, out_valid_next;

    logic [llh_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [llh_pkg::IDX_W-1:0]         walk_idx_reg, walk_idx_next;
    logic [llh_pkg::STAT_W-1:0]        target_reg, target_next;
    logic [llh_pkg::STAT_W-1:0]        cum_reg, cum_next;
    logic [llh_pkg::ANSWER_W-1:0]      ans_reg, ans_next;
    logic                              bad_reg, bad_next;
    logic [llh_pkg::ANSWER_W-1:0]      out_answer_reg, out_answer_next;
    logic [llh_pkg::SCOUNT_W-1:0]      out_count_reg, out_count_next;
    logic                              out_bad_reg, out_bad_next;

    logic                              ram_we;
    logic [llh_pkg::IDX_W-1:0]         ram_waddr, ram_raddr;
    logic [llh_pkg::COUNT_BITS-1:0]    ram_wdata, ram_rdata;

    llh_pkg::arith_cmd_t               arith_cmd;
    llh_pkg::arith_rsp_t               arith_rsp;

    logic                              accept;
    logic                              is_small;
    logic                              total_zero;
    logic                              q_bad;
    logic                              clr_last;
    logic                              walk_last;
    logic                              walk_hit;
    logic                              out_free;
    logic [llh_pkg::STAT_W:0]          cum_sum;
    logic [llh_pkg::STAT_W-1:0]        cum_sat;
    logic [llh_pkg::IDX_W-1:0]         norm_idx;

    llh_ram #(
        .WIDTH (llh_pkg::COUNT_BITS),
        .DEPTH (llh_pkg::NBUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    llh_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (arith_cmd),
        .rsp   (arith_rsp)
    );

    assign req.ready        = (state_reg == llh_pkg::ST_IDLE);
    assign accept           = req.valid && req.ready;
    assign is_small         = req.latency < llh_pkg::LAT_W'(llh_pkg::LINEAR_COUNT);
    assign total_zero       = (total_reg == '0);
    assign q_bad            = (req.quantile_frac == '0)
                           || (req.quantile_frac > llh_pkg::Q_W'(llh_pkg::Q_ONE));
    assign clr_last         = (clr_idx_reg == llh_pkg::IDX_W'(llh_pkg::NBUCKETS - 1));
    assign walk_last        = (walk_idx_reg == llh_pkg::IDX_W'(llh_pkg::NBUCKETS - 1));
    assign cum_sum          = {1'b0, cum_reg} + (llh_pkg::STAT_W+1)'(ram_rdata);
    assign cum_sat          = cum_sum[llh_pkg::STAT_W] ? '1 : cum_sum[llh_pkg::STAT_W-1:0];
    assign walk_hit         = (cum_sat >= target_reg);
    assign out_free         = !out_valid_reg || rsp.ready;

    // Octave and sub-bucket from the normalized sample
    assign norm_idx = llh_pkg::IDX_W'(llh_pkg::LINEAR_COUNT)
                    + (llh_pkg::IDX_W'(arith_rsp.expo - llh_pkg::EXP_W'(llh_pkg::LINEAR_BITS))
                       << llh_pkg::SUB_BITS)
                    + llh_pkg::IDX_W'(arith_rsp.value[llh_pkg::VALUE_BITS-2 -: llh_pkg::SUB_BITS]);

    assign rsp.valid        = out_valid_reg;
    assign rsp.answer       = out_answer_reg;
    assign rsp.sample_count = out_count_reg;
    assign rsp.bad_quantile = out_bad_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            llh_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = llh_pkg::ST_IDLE;
                end
            end
            llh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.action)
                        llh_pkg::ACT_RECORD:
                        begin
                            state_next = is_small ? llh_pkg::ST_REC_READ : llh_pkg::ST_REC_NORM;
                        end
                        llh_pkg::ACT_PERCENTILE:
                        begin
                            state_next = (total_zero || q_bad) ? llh_pkg::ST_EMIT
                                                               : llh_pkg::ST_TARGET;
                        end
                        llh_pkg::ACT_MEAN:
                        begin
                            state_next = total_zero ? llh_pkg::ST_EMIT : llh_pkg::ST_MEAN;
                        end
                        default:
                        begin
                            state_next = llh_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            llh_pkg::ST_REC_NORM:
            begin
                if (arith_rsp.done)
                begin
                    state_next = llh_pkg::ST_REC_READ;
                end
            end
            llh_pkg::ST_REC_READ:
            begin
                state_next = llh_pkg::ST_REC_WRITE;
            end
            llh_pkg::ST_REC_WRITE:
            begin
                state_next = llh_pkg::ST_IDLE;
            end
            llh_pkg::ST_TARGET:
            begin
                if (arith_rsp.done)
                begin
                    state_next = llh_pkg::ST_WALK_FIRST;
                end
            end
            llh_pkg::ST_WALK_FIRST:
            begin
                state_next = llh_pkg::ST_WALK;
            end
            llh_pkg::ST_WALK:
            begin
                if (walk_hit || walk_last)
                begin
                    state_next = llh_pkg::ST_EMIT;
                end
            end
            llh_pkg::ST_MEAN:
            begin
                if (arith_rsp.done)
                begin
                    state_next = llh_pkg::ST_EMIT;
                end
            end
            llh_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = llh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = llh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_idx_next    = clr_idx_reg;
        total_next      = total_reg;
        sum_next        = sum_reg;
        idx_next        = idx_reg;
        walk_idx_next   = walk_idx_reg;
        target_next     = target_reg;
        cum_next        = cum_reg;
        ans_next        = ans_reg;
        bad_next        = bad_reg;
        out_answer_next = out_answer_reg;
        out_count_next  = out_count_reg;
        out_bad_next    = out_bad_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;
        ram_raddr       = idx_reg;
        arith_cmd       = '0;

        unique case (state_reg)
            llh_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + llh_pkg::IDX_W'(1);
            end
            llh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ans_next = '0;
                    bad_next = 1'b0;
                    unique case (req.action)
                        llh_pkg::ACT_RECORD:
                        begin
                            total_next = total_reg + llh_pkg::STAT_W'(1);
                            sum_next   = sum_reg + llh_pkg::STAT_W'(req.latency);
                            idx_next   = llh_pkg::IDX_W'(req.latency);
                            if (!is_small)
                            begin
                                arith_cmd.start = 1'b1;
                                arith_cmd.op    = llh_pkg::OP_NORM;
                                arith_cmd.a     = llh_pkg::STAT_W'(req.latency);
                            end
                        end
                        llh_pkg::ACT_PERCENTILE:
                        begin
                            if (!total_zero)
                            begin
                                if (q_bad)
                                begin
                                    bad_next = 1'b1;
                                end
                                else
                                begin
                                    arith_cmd.start = 1'b1;
                                    arith_cmd.op    = llh_pkg::OP_MUL;
                                    arith_cmd.a     = total_reg;
                                    arith_cmd.b     = llh_pkg::STAT_W'(req.quantile_frac);
                                end
                            end
                        end
                        llh_pkg::ACT_MEAN:
                        begin
                            if (!total_zero)
                            begin
                                arith_cmd.start = 1'b1;
                                arith_cmd.op    = llh_pkg::OP_DIV;
                                arith_cmd.a     = sum_reg;
                                arith_cmd.b     = total_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            llh_pkg::ST_REC_NORM:
            begin
                if (arith_rsp.done)
                begin
                    idx_next = norm_idx;
                end
            end
            llh_pkg::ST_REC_READ:
            begin
                ram_raddr = idx_reg;
            end
            llh_pkg::ST_REC_WRITE:
            begin
                // saturate the bucket counter
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = (ram_rdata == '1) ? ram_rdata
                                              : ram_rdata + llh_pkg::COUNT_BITS'(1);
            end
            llh_pkg::ST_TARGET:
            begin
                if (arith_rsp.done)
                begin
                    target_next = arith_rsp.value;
                    cum_next    = '0;
                end
            end
            llh_pkg::ST_WALK_FIRST:
            begin
                ram_raddr     = '0;
                walk_idx_next = '0;
            end
            llh_pkg::ST_WALK:
            begin
                cum_next  = cum_sat;
                ram_raddr = walk_last ? walk_idx_reg : walk_idx_reg + llh_pkg::IDX_W'(1);
                if (walk_hit || walk_last)
                begin
                    ans_next = llh_pkg::ANSWER_W'(llh_pkg::bucket_upper(walk_idx_reg));
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + llh_pkg::IDX_W'(1);
                end
            end
            llh_pkg::ST_MEAN:
            begin
                if (arith_rsp.done)
                begin
                    ans_next = arith_rsp.value[llh_pkg::ANSWER_W-1:0];
                end
            end
            llh_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_answer_next = ans_reg;
                    out_count_next  = total_reg[llh_pkg::SCOUNT_W-1:0];
                    out_bad_next    = bad_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= llh_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            total_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            total_reg     <= total_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        walk_idx_reg   <= walk_idx_next;
        target_reg     <= target_next;
        cum_reg        <= cum_next;
        ans_reg        <= ans_next;
        bad_reg        <= bad_next;
        out_answer_reg <= out_answer_next;
        out_count_reg  <= out_count_next;
        out_bad_reg    <= out_bad_next;
    end

endmodule

// ----- rtl/llh_ram.sv -----
`timescale 1ns / 1ps

module llh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/llh_arith.sv -----
`timescale 1ns / 1ps

module llh_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  llh_pkg::arith_cmd_t cmd,
    output llh_pkg::arith_rsp_t rsp
);

    llh_pkg::arith_state_t              state_reg, state_next;
    llh_pkg::arith_op_t                 op_reg, op_next;
    logic [llh_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [llh_pkg::ADD_W-1:0]          acc_reg, acc_next;
    logic [llh_pkg::ADD_W-1:0]          mcand_reg, mcand_next;
    logic [llh_pkg::Q_W-1:0]            mplier_reg, mplier_next;
    logic [llh_pkg::STAT_W:0]           rem_reg, rem_next;
    logic [llh_pkg::STAT_W-1:0]         quo_reg, quo_next;
    logic [llh_pkg::VALUE_BITS-1:0]     norm_reg, norm_next;
    logic [llh_pkg::EXP_W-1:0]          expo_reg, expo_next;

    logic [llh_pkg::ADD_W-1:0]          add_x, add_y, add_sum;
    logic                               add_cin;
    logic [llh_pkg::STAT_W:0]           rem_sh;
    logic                               last_step;

    assign rem_sh    = {rem_reg[llh_pkg::STAT_W-1:0], quo_reg[llh_pkg::STAT_W-1]};
    assign last_step = (op_reg == llh_pkg::OP_MUL)
                     ? (step_reg == llh_pkg::STEP_W'(llh_pkg::Q_W - 1))
                     : (step_reg == llh_pkg::STEP_W'(llh_pkg::STAT_W - 1));

    // The one adder shared by multiply, round and divide
    assign add_sum = add_x + add_y + llh_pkg::ADD_W'(add_cin);

    always_comb
    begin
        add_x   = acc_reg;
        add_y   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            llh_pkg::AR_RUN:
            begin
                if (op_reg == llh_pkg::OP_MUL)
                begin
                    add_y = mplier_reg[0] ? mcand_reg : '0;
                end
                else if (op_reg == llh_pkg::OP_DIV)
                begin
                    add_x   = llh_pkg::ADD_W'(rem_sh);
                    add_y   = ~llh_pkg::ADD_W'(mcand_reg[llh_pkg::STAT_W-1:0]);
                    add_cin = 1'b1;
                end
            end
            llh_pkg::AR_ROUND:
            begin
                add_y = llh_pkg::ADD_W'(llh_pkg::Q_ONE - 1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            llh_pkg::AR_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = llh_pkg::AR_RUN;
                end
            end
            llh_pkg::AR_RUN:
            begin
                unique case (op_reg)
                    llh_pkg::OP_NORM:
                    begin
                        if (norm_reg[llh_pkg::VALUE_BITS-1])
                        begin
                            state_next = llh_pkg::AR_DONE;
                        end
                    end
                    llh_pkg::OP_MUL:
                    begin
                        if (last_step)
                        begin
                            state_next = llh_pkg::AR_ROUND;
                        end
                    end
                    llh_pkg::OP_DIV:
                    begin
                        if (last_step)
                        begin
                            state_next = llh_pkg::AR_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = llh_pkg::AR_DONE;
                    end
                endcase
            end
            llh_pkg::AR_ROUND:
            begin
                state_next = llh_pkg::AR_DONE;
            end
            llh_pkg::AR_DONE:
            begin
                state_next = llh_pkg::AR_IDLE;
            end
            default:
            begin
                state_next = llh_pkg::AR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        step_next   = step_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        norm_next   = norm_reg;
        expo_next   = expo_reg;
        unique case (state_reg)
            llh_pkg::AR_IDLE:
            begin
                if (cmd.start)
                begin
                    op_next     = cmd.op;
                    step_next   = '0;
                    acc_next    = '0;
                    mcand_next  = (cmd.op == llh_pkg::OP_DIV) ? llh_pkg::ADD_W'(cmd.b)
                                                              : llh_pkg::ADD_W'(cmd.a);
                    mplier_next = cmd.b[llh_pkg::Q_W-1:0];
                    rem_next    = '0;
                    quo_next    = cmd.a;
                    norm_next   = cmd.a[llh_pkg::VALUE_BITS-1:0];
                    expo_next   = llh_pkg::EXP_W'(llh_pkg::VALUE_BITS - 1);
                end
            end
            llh_pkg::AR_RUN:
            begin
                unique case (op_reg)
                    llh_pkg::OP_NORM:
                    begin
                        // shift until the leading one reaches the top bit
                        if (!norm_reg[llh_pkg::VALUE_BITS-1])
                        begin
                            norm_next = norm_reg << 1;
                            expo_next = expo_reg - llh_pkg::EXP_W'(1);
                        end
                    end
                    llh_pkg::OP_MUL:
                    begin
                        acc_next    = add_sum;
                        mcand_next  = mcand_reg << 1;
                        mplier_next = mplier_reg >> 1;
                        step_next   = step_reg + llh_pkg::STEP_W'(1);
                    end
                    llh_pkg::OP_DIV:
                    begin
                        // restoring step: keep the difference unless it went negative
                        if (!add_sum[llh_pkg::ADD_W-1])
                        begin
                            rem_next = add_sum[llh_pkg::STAT_W:0];
                            quo_next = {quo_reg[llh_pkg::STAT_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next = rem_sh;
                            quo_next = {quo_reg[llh_pkg::STAT_W-2:0], 1'b0};
                        end
                        step_next = step_reg + llh_pkg::STEP_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            llh_pkg::AR_ROUND:
            begin
                acc_next = add_sum;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp.done = (state_reg == llh_pkg::AR_DONE);
        rsp.expo = expo_reg;
        unique case (op_reg)
            llh_pkg::OP_MUL:  rsp.value = acc_reg[llh_pkg::Q_FRAC_BITS +: llh_pkg::STAT_W];
            llh_pkg::OP_DIV:  rsp.value = quo_reg;
            default:          rsp.value = llh_pkg::STAT_W'(norm_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= llh_pkg::AR_IDLE;
            op_reg    <= llh_pkg::OP_NORM;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        norm_reg   <= norm_next;
        expo_reg   <= expo_next;
    end

endmodule

// ----- test/tb_log_linear_latency_histogram.sv -----
`timescale 1ns / 1ps

module tb_log_linear_latency_histogram;
    import llh_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 430;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LAT_W-1:0]    latency;
        logic [Q_W-1:0]      quantile_frac;
    } llh_request_t;

    typedef struct packed {
        logic [ANSWER_W-1:0] answer;
        logic [SCOUNT_W-1:0] sample_count;
        logic                bad_quantile;
    } llh_answer_t;

    logic clk = 1'b0;
    logic rst_n;

    llh_req_if req ();
    llh_rsp_if rsp ();

    log_linear_latency_histogram dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow histogram
    logic [COUNT_BITS-1:0] bucket_tally [NBUCKETS];
    logic [STAT_W-1:0]     sample_total;
    logic [STAT_W-1:0]     latency_total;

    llh_request_t request_queue [$];
    llh_answer_t  expected_answers [$];
    int unsigned  request_total;
    int unsigned  requests_seen;
    int unsigned  fail_count;
    int unsigned  idle_cycles;

    function automatic int unsigned bucket_index(input logic [LAT_W-1:0] v);
        int unsigned msb;
        int unsigned sub;
        if (v < LINEAR_COUNT)
        begin
            return v;
        end
        msb = 0;
        for (int i = 0; i < LAT_W; i++)
        begin
            if (v[i])
            begin
                msb = i;
            end
        end
        sub = ((v - (32'd1 << msb)) >> (msb - SUB_BITS)) & ((1 << SUB_BITS) - 1);
        return LINEAR_COUNT + ((msb - LINEAR_BITS) << SUB_BITS) + sub;
    endfunction

    function automatic logic [STAT_W-1:0] bucket_ceiling(input int unsigned b);
        int unsigned       rel;
        int unsigned       msb;
        int unsigned       sub;
        logic [STAT_W-1:0] base;
        if (b < LINEAR_COUNT)
        begin
            return STAT_W'(b);
        end
        rel  = b - LINEAR_COUNT;
        msb  = (rel >> SUB_BITS) + LINEAR_BITS;
        sub  = rel & ((1 << SUB_BITS) - 1);
        base = 64'd1 << msb;
        return base + (base >> SUB_BITS) * STAT_W'(sub + 1) - 64'd1;
    endfunction

    // Apply one beat to the shadow histogram; returns 1 when it produces a result.
    function automatic bit histogram_step(input llh_request_t beat, output llh_answer_t res);
        logic [STAT_W-1:0] hi;
        logic [STAT_W-1:0] lo;
        logic [STAT_W-1:0] q;
        logic [STAT_W-1:0] target;
        logic [STAT_W-1:0] cum;
        logic [STAT_W-1:0] c;
        logic [STAT_W-1:0] answer;
        logic              bad;
        int unsigned       idx;
        res    = '0;
        answer = '0;
        bad    = 1'b0;
        case (beat.action)
            ACT_RECORD:
            begin
                idx = bucket_index(beat.latency);
                if (bucket_tally[idx] != '1)
                begin
                    bucket_tally[idx]++;
                end
                sample_total  = sample_total + 64'd1;
                latency_total = latency_total + STAT_W'(beat.latency);
                return 1'b0;
            end
            ACT_PERCENTILE:
            begin
                if (sample_total != 0)
                begin
                    q = STAT_W'(beat.quantile_frac);
                    if (q == 0 || q > Q_ONE)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        hi     = sample_total >> 16;
                        lo     = sample_total & 64'hFFFF;
                        target = hi * q + ((lo * q + (Q_ONE - 1)) >> 16);
                        answer = bucket_ceiling(NBUCKETS - 1);
                        cum    = '0;
                        for (int i = 0; i < NBUCKETS; i++)
                        begin
                            c   = STAT_W'(bucket_tally[i]);
                            cum = (cum > ~c) ? '1 : cum + c;
                            if (cum >= target)
                            begin
                                answer = bucket_ceiling(i);
                                break;
                            end
                        end
                    end
                end
            end
            ACT_MEAN:
            begin
                if (sample_total != 0)
                begin
                    answer = latency_total / sample_total;
                end
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        res.answer       = answer[ANSWER_W-1:0];
        res.sample_count = sample_total[SCOUNT_W-1:0];
        res.bad_quantile = bad;
        return 1'b1;
    endfunction

    function automatic void push_request(input logic [ACTION_W-1:0] action,
                                         input logic [LAT_W-1:0] latency,
                                         input logic [Q_W-1:0] quantile_frac);
        llh_request_t beat;
        beat.action        = action;
        beat.latency       = latency;
        beat.quantile_frac = quantile_frac;
        request_queue.insert(request_queue.size(), beat);
    endfunction

    // Idle phases run in quarters of the item stream: none, sender, receiver, both.
    function automatic bit sender_pauses();
        int unsigned phase;
        phase = (request_total - request_queue.size()) * 4 / request_total;
        case (phase)
            1:       return $urandom_range(0, 99) < 70;
            3:       return $urandom_range(0, 99) < 34;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        int unsigned phase;
        phase = requests_seen * 4 / request_total;
        case (phase)
            2:       return $urandom_range(0, 99) < 70;
            3:       return $urandom_range(0, 99) < 34;
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        llh_request_t beat;
        if (!rst_n)
        begin
            req.valid         <= 1'b0;
            req.action        <= ACT_RECORD;
            req.latency       <= '0;
            req.quantile_frac <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (request_queue.size() != 0 && !sender_pauses())
            begin
                beat = request_queue.pop_front();
                req.valid         <= 1'b1;
                req.action        <= beat.action;
                req.latency       <= beat.latency;
                req.quantile_frac <= beat.quantile_frac;
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        llh_request_t beat;
        llh_answer_t  got;
        llh_answer_t  want;
        llh_answer_t  predicted;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= !receiver_stalls();
            if (rsp.valid && rsp.ready)
            begin
                got.answer       = rsp.answer;
                got.sample_count = rsp.sample_count;
                got.bad_quantile = rsp.bad_quantile;
                if (expected_answers.size() == 0)
                begin
                    $error("unexpected result: answer %0d sample_count %0d bad_quantile %0b",
                           got.answer, got.sample_count, got.bad_quantile);
                    fail_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.answer !== want.answer)
                    begin
                        $error("answer: expected %0d, actual %0d", want.answer, got.answer);
                        fail_count++;
                    end
                    if (got.sample_count !== want.sample_count)
                    begin
                        $error("sample_count: expected %0d, actual %0d",
                               want.sample_count, got.sample_count);
                        fail_count++;
                    end
                    if (got.bad_quantile !== want.bad_quantile)
                    begin
                        $error("bad_quantile: expected %0b, actual %0b",
                               want.bad_quantile, got.bad_quantile);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                beat.action        = req.action;
                beat.latency       = req.latency;
                beat.quantile_frac = req.quantile_frac;
                requests_seen++;
                if (histogram_step(beat, predicted))
                begin
                    expected_answers.insert(expected_answers.size(), predicted);
                end
            end
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int unsigned      made;
        int unsigned      pick;
        logic [LAT_W-1:0] lat;
        logic [Q_W-1:0]   qf;

        rst_n             = 1'b0;
        requests_seen     = 0;
        fail_count        = 0;
        idle_cycles       = 0;
        sample_total      = '0;
        latency_total     = '0;
        for (int i = 0; i < NBUCKETS; i++)
        begin
            bucket_tally[i] = '0;
        end

        // Queries on an empty histogram, a zero quantile among them
        push_request(ACT_PERCENTILE, $urandom, 17'd32768);
        push_request(ACT_MEAN, $urandom, Q_W'($urandom));
        push_request(ACT_PERCENTILE, $urandom, 17'd0);
        // Edges of the linear range, octave boundaries and the full width
        push_request(ACT_RECORD, 32'd0, 17'h1FFFF);
        push_request(ACT_RECORD, 32'd1, 17'd0);
        push_request(ACT_RECORD, 32'd1023, Q_W'($urandom));
        push_request(ACT_RECORD, 32'd1024, Q_W'($urandom));
        push_request(ACT_RECORD, 32'd1025, Q_W'($urandom));
        push_request(ACT_RECORD, 32'd2047, Q_W'($urandom));
        push_request(ACT_RECORD, 32'd2048, Q_W'($urandom));
        push_request(ACT_RECORD, 32'd1234567, Q_W'($urandom));
        push_request(ACT_RECORD, 32'h8000_0000, Q_W'($urandom));
        push_request(ACT_RECORD, 32'hFFFF_FFFF, Q_W'($urandom));
        // Smallest and largest quantile, invalid ones, the median
        push_request(ACT_PERCENTILE, $urandom, 17'd1);
        push_request(ACT_PERCENTILE, $urandom, 17'd65536);
        push_request(ACT_PERCENTILE, $urandom, 17'd0);
        push_request(ACT_PERCENTILE, $urandom, 17'd65537);
        push_request(ACT_PERCENTILE, $urandom, 17'h1FFFF);
        push_request(ACT_PERCENTILE, $urandom, 17'd32768);
        push_request(ACT_MEAN, $urandom, Q_W'($urandom));
        // Unused action must leave the histogram alone
        push_request(ACT_UNUSED, 32'hFFFF_FFFF, 17'h1FFFF);
        push_request(ACT_MEAN, 32'd0, 17'd0);

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                case ($urandom_range(0, 3))
                    0:       lat = $urandom_range(0, LINEAR_COUNT - 1);
                    1:       lat = $urandom_range(LINEAR_COUNT, 65535);
                    2:       lat = $urandom >> $urandom_range(0, 31);
                    default: lat = $urandom;
                endcase
                push_request(ACT_RECORD, lat, Q_W'($urandom));
                made++;
            end
            else if (pick < 78)
            begin
                case ($urandom_range(0, 19))
                    0:       qf = '0;
                    1:       qf = Q_W'($urandom_range(Q_ONE + 1, (1 << Q_W) - 1));
                    2:       qf = Q_W'(Q_ONE);
                    3:       qf = 17'd1;
                    default: qf = Q_W'($urandom_range(1, Q_ONE));
                endcase
                push_request(ACT_PERCENTILE, $urandom, qf);
                made++;
            end
            else if (pick < 95)
            begin
                push_request(ACT_MEAN, $urandom, Q_W'($urandom));
                made++;
            end
            else
            begin
                push_request(ACT_UNUSED, $urandom, Q_W'($urandom));
            end
        end
        request_total = request_queue.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_seen < request_total)
        begin
            @(posedge clk);
        end
        while (expected_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_answers.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/llh_pkg.sv
rtl/llh_req_if.sv
rtl/llh_rsp_if.sv
rtl/llh_ram.sv
rtl/llh_arith.sv
rtl/log_linear_latency_histogram.sv
test/tb_log_linear_latency_histogram.sv
